### design/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared constants, types and helpers for the keyed table block.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BYTES = 8;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [63:0] KEY_MASK = ~64'h0 << (64 - 8 * KEY_BYTES);

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_REMOVE  = 3'd1;
  localparam logic [2:0] MODE_LIST    = 3'd2;
  localparam logic [2:0] MODE_LSEARCH = 3'd3;
  localparam logic [2:0] MODE_SORT    = 3'd4;
  localparam logic [2:0] MODE_BSEARCH = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_NOTSORTED = 3'd4;

  typedef struct packed {
    logic [63:0]        name;
    logic [63:0]        kind;
    logic signed [31:0] amount;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  hit_index;
    logic [4:0]  compare_count;
    logic [4:0]  entry_count;
    logic        sorted_now;
    entry_t      entry;
    logic        last;
  } result_t;

  function automatic result_t mk_res(input logic [2:0] status, input logic [31:0] idx,
                                     input logic [31:0] cmps, input logic [31:0] cnt,
                                     input logic flag, input entry_t e, input logic last);
    result_t r;
    r.status        = status;
    r.hit_index     = idx[3:0];
    r.compare_count = cmps[4:0];
    r.entry_count   = cnt[4:0];
    r.sorted_now    = flag;
    r.entry         = e;
    r.last          = last;
    return r;
  endfunction

endpackage

### design/kts_ram.sv
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/kts_ctrl.sv
// ----------------------------------------------------------------------------
// kts_ctrl
// Operation sequencer: scans, shifts, bubble sort and binary search over
// the entry RAM, at most one RAM read per cycle.
// ----------------------------------------------------------------------------
module kts_ctrl import kts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic [63:0]        key_name_i,
  input  logic [63:0]        kind_word_i,
  input  logic signed [31:0] amount_i,
  output ram_req_t           ram_req_o,
  input  entry_t             ram_rdata_i,
  output logic               emit_valid_o,
  input  logic               emit_ready_i,
  output result_t            emit_res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RM_SCAN, S_RM_SHIFT, S_LS_SCAN, S_LI_RD, S_LI_GET,
    S_SO_START, S_SO_LOAD, S_SO_CMP, S_SO_END, S_BS_RD, S_BS_CMP, S_EMIT
  } state_e;

  state_e             state_q, state_d, ret_q, ret_d;
  logic [2:0]         mode_q, mode_d;
  logic [63:0]        key_q, key_d, kind_q, kind_d;
  logic signed [31:0] amt_q, amt_d;
  logic [CNT_W-1:0]   n_q, n_d, lo_q, lo_d, hi_q, hi_d, cmps_q, cmps_d;
  logic               flag_q, flag_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, lim_q, lim_d;
  entry_t             carry_q, carry_d, buf_q, buf_d;
  result_t            res_q, res_d;

  logic [CNT_W-1:0]   i_nx, j_nx1, j_nx2, mid;
  entry_t             new_e;
  ram_req_t           req;

  always_comb begin
    i_nx  = CNT_W'(i_q) + CNT_W'(1);
    j_nx1 = CNT_W'(j_q) + CNT_W'(1);
    j_nx2 = CNT_W'(j_q) + CNT_W'(2);
    mid   = lo_q + ((hi_q - CNT_W'(1) - lo_q) >> 1);
    new_e = '{name: key_q, kind: kind_q, amount: amt_q};

    state_d = state_q;
    ret_d   = ret_q;
    mode_d  = mode_q;
    key_d   = key_q;
    kind_d  = kind_q;
    amt_d   = amt_q;
    n_d     = n_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    cmps_d  = cmps_q;
    flag_d  = flag_q;
    i_d     = i_q;
    j_d     = j_q;
    lim_d   = lim_q;
    carry_d = carry_q;
    buf_d   = buf_q;
    res_d   = res_q;
    req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          key_d   = key_name_i & KEY_MASK;
          kind_d  = kind_word_i;
          amt_d   = amount_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ret_d   = S_IDLE;
        state_d = S_EMIT;
        case (mode_q)
          MODE_INSERT: begin
            if (32'(n_q) >= CAPACITY) begin
              res_d = mk_res(ST_FULL, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
            end else begin
              req.we    = 1'b1;
              req.waddr = n_q[IDX_W-1:0];
              req.wdata = new_e;
              n_d       = n_q + CNT_W'(1);
              flag_d    = 1'b0;
              res_d     = mk_res(ST_OK, 32'(n_q), 0, 32'(n_d), 1'b0, new_e, 1'b1);
            end
          end
          MODE_REMOVE, MODE_LSEARCH: begin
            if (n_q == '0) begin
              res_d = mk_res(ST_EMPTY, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
            end else begin
              i_d       = '0;
              req.re    = 1'b1;
              req.raddr = '0;
              state_d   = (mode_q == MODE_REMOVE) ? S_RM_SCAN : S_LS_SCAN;
            end
          end
          MODE_LIST: begin
            if (n_q == '0) begin
              res_d = mk_res(ST_EMPTY, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
            end else begin
              i_d     = '0;
              state_d = S_LI_RD;
            end
          end
          MODE_SORT: begin
            if (n_q < CNT_W'(2)) begin
              flag_d = 1'b1;
              res_d  = mk_res(ST_OK, 0, 0, 32'(n_q), 1'b1, '0, 1'b1);
            end else begin
              lim_d   = IDX_W'(n_q - CNT_W'(1));
              state_d = S_SO_START;
            end
          end
          MODE_BSEARCH: begin
            if (!flag_q) begin
              res_d = mk_res(ST_NOTSORTED, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
            end else if (n_q == '0) begin
              res_d = mk_res(ST_EMPTY, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
            end else begin
              lo_d    = '0;
              hi_d    = n_q;
              cmps_d  = '0;
              state_d = S_BS_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RM_SCAN: begin
        if (ram_rdata_i.name == key_q) begin
          buf_d = ram_rdata_i;
          if (i_nx < n_q) begin
            req.re    = 1'b1;
            req.raddr = i_nx[IDX_W-1:0];
            j_d       = i_q;
            state_d   = S_RM_SHIFT;
          end else begin
            n_d     = n_q - CNT_W'(1);
            flag_d  = 1'b0;
            res_d   = mk_res(ST_OK, 32'(i_q), 0, 32'(n_d), 1'b0, ram_rdata_i, 1'b1);
            state_d = S_EMIT;
          end
        end else if (i_nx == n_q) begin
          res_d   = mk_res(ST_NOTFOUND, 0, 0, 32'(n_q), flag_q, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          req.re    = 1'b1;
          req.raddr = i_nx[IDX_W-1:0];
          i_d       = i_nx[IDX_W-1:0];
        end
      end
      S_RM_SHIFT: begin
        req.we    = 1'b1;
        req.waddr = j_q;
        req.wdata = ram_rdata_i;
        if (j_nx2 < n_q) begin
          req.re    = 1'b1;
          req.raddr = j_nx2[IDX_W-1:0];
          j_d       = j_nx1[IDX_W-1:0];
        end else begin
          n_d     = n_q - CNT_W'(1);
          flag_d  = 1'b0;
          res_d   = mk_res(ST_OK, 32'(i_q), 0, 32'(n_d), 1'b0, buf_q, 1'b1);
          state_d = S_EMIT;
        end
      end
      S_LS_SCAN: begin
        if (ram_rdata_i.name == key_q) begin
          res_d   = mk_res(ST_OK, 32'(i_q), 32'(i_nx), 32'(n_q), flag_q, ram_rdata_i, 1'b1);
          state_d = S_EMIT;
        end else if (i_nx == n_q) begin
          res_d   = mk_res(ST_NOTFOUND, 0, 32'(n_q), 32'(n_q), flag_q, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          req.re    = 1'b1;
          req.raddr = i_nx[IDX_W-1:0];
          i_d       = i_nx[IDX_W-1:0];
        end
      end
      S_LI_RD: begin
        req.re    = 1'b1;
        req.raddr = i_q;
        state_d   = S_LI_GET;
      end
      S_LI_GET: begin
        res_d   = mk_res(ST_OK, 32'(i_q), 0, 32'(n_q), flag_q, ram_rdata_i, i_nx == n_q);
        ret_d   = (i_nx == n_q) ? S_IDLE : S_LI_RD;
        i_d     = i_nx[IDX_W-1:0];
        state_d = S_EMIT;
      end
      S_SO_START: begin
        req.re    = 1'b1;
        req.raddr = '0;
        j_d       = '0;
        state_d   = S_SO_LOAD;
      end
      S_SO_LOAD: begin
        carry_d   = ram_rdata_i;
        req.re    = 1'b1;
        req.raddr = IDX_W'(1);
        state_d   = S_SO_CMP;
      end
      S_SO_CMP: begin
        req.we    = 1'b1;
        req.waddr = j_q;
        if (carry_q.name > ram_rdata_i.name) begin
          req.wdata = ram_rdata_i;
        end else begin
          req.wdata = carry_q;
          carry_d   = ram_rdata_i;
        end
        if (j_nx1 < CNT_W'(lim_q)) begin
          req.re    = 1'b1;
          req.raddr = j_nx2[IDX_W-1:0];
          j_d       = j_nx1[IDX_W-1:0];
        end else begin
          state_d = S_SO_END;
        end
      end
      S_SO_END: begin
        req.we    = 1'b1;
        req.waddr = j_nx1[IDX_W-1:0];
        req.wdata = carry_q;
        if (lim_q == IDX_W'(1)) begin
          flag_d  = 1'b1;
          res_d   = mk_res(ST_OK, 0, 0, 32'(n_q), 1'b1, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          lim_d   = lim_q - IDX_W'(1);
          state_d = S_SO_START;
        end
      end
      S_BS_RD: begin
        if (lo_q < hi_q) begin
          req.re    = 1'b1;
          req.raddr = mid[IDX_W-1:0];
          i_d       = mid[IDX_W-1:0];
          cmps_d    = cmps_q + CNT_W'(1);
          state_d   = S_BS_CMP;
        end else begin
          res_d   = mk_res(ST_NOTFOUND, 0, 32'(cmps_q), 32'(n_q), flag_q, '0, 1'b1);
          state_d = S_EMIT;
        end
      end
      S_BS_CMP: begin
        if (ram_rdata_i.name == key_q) begin
          res_d   = mk_res(ST_OK, 32'(i_q), 32'(cmps_q), 32'(n_q), flag_q, ram_rdata_i,
                           1'b1);
          state_d = S_EMIT;
        end else begin
          if (ram_rdata_i.name < key_q) begin
            lo_d = i_nx;
          end else begin
            hi_d = CNT_W'(i_q);
          end
          state_d = S_BS_RD;
        end
      end
      S_EMIT: begin
        if (emit_ready_i) begin
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      n_q     <= '0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      n_q     <= n_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    kind_q  <= kind_d;
    amt_q   <= amt_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    cmps_q  <= cmps_d;
    i_q     <= i_d;
    j_q     <= j_d;
    lim_q   <= lim_d;
    carry_q <= carry_d;
    buf_q   <= buf_d;
    res_q   <= res_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign ram_req_o    = req;
  assign emit_valid_o = (state_q == S_EMIT);
  assign emit_res_o   = res_q;

endmodule

### design/keyed_table_sort_search.sv
// ----------------------------------------------------------------------------
// keyed_table_sort_search
// Keyed table with insert, remove, list, linear/binary search and sort.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a single read and a single write port and a
// registered read. Insert writes the new entry at the end; remove, linear
// search and list scan the entries in order, remove then shifts the later
// entries down; binary search halves the range on each compare; sort runs
// bubble passes with one compare per RAM read. One transaction is worked
// at a time; results leave through an output register, so a new
// transaction may be accepted while the final result still waits.
module keyed_table_sort_search import kts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic [63:0]        key_name_i,
  input  logic [63:0]        kind_word_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [3:0]         hit_index_o,
  output logic [4:0]         compare_count_o,
  output logic [4:0]         entry_count_o,
  output logic               sorted_now_o,
  output logic [63:0]        out_name_o,
  output logic [63:0]        out_kind_o,
  output logic signed [31:0] out_amount_o,
  output logic               last_o
);

  ram_req_t ram_req;
  entry_t   ram_rdata;
  logic     emit_valid, emit_ready;
  result_t  emit_res, out_q;
  logic     out_valid_q;

  kts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .key_name_i   (key_name_i),
    .kind_word_i  (kind_word_i),
    .amount_i     (amount_i),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_res_o   (emit_res)
  );

  kts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign hit_index_o     = out_q.hit_index;
  assign compare_count_o = out_q.compare_count;
  assign entry_count_o   = out_q.entry_count;
  assign sorted_now_o    = out_q.sorted_now;
  assign out_name_o      = out_q.entry.name;
  assign out_kind_o      = out_q.entry.kind;
  assign out_amount_o    = out_q.entry.amount;
  assign last_o          = out_q.last;

endmodule
